[src/tensor_transpose_offset_assert.svh]
// assertion macros for the checker of this block
`ifndef TENSOR_TRANSPOSE_OFFSET_ASSERT_SVH
`define TENSOR_TRANSPOSE_OFFSET_ASSERT_SVH

// consequent in the same cycle
`define TTOFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define TTOFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ttoff_pkg.sv]
package ttoff_pkg;

  localparam int IDX_W     = 48;
  localparam int RANK_W    = 3;
  localparam int DIMS_W    = 48;
  localparam int PERM_W    = 18;
  localparam int AXIS_BITS = 3;
  localparam int BPS       = 4;
  localparam int NSTEP     = IDX_W / BPS;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERM = 2'd2;

  localparam logic [RANK_W-1:0] RANK_RST = 3'd1;
  localparam logic [PERM_W-1:0] PERM_RST = 18'd181896;

endpackage

[src/tensor_transpose_offset.sv]
// transposed-tensor offset generator
// in_*  : stream of input words, in_tdata = linear_index (row-major input index)
// out_* : one result word per input word, out_tdata = out_offset,
//         out_tuser = {bad_permutation, out_of_range}
// cfg_* : register writes, index 0 rank, 1 dims_minus_one, 2 permutation;
//         cfg_ready is always high, write only while no word is in flight
// pipeline: MAX_RANK*(48/4) divide stages, MAX_RANK recombine stages and the
//   output register; the index is split one axis at a time, four quotient
//   bits per stage
// throughput: one word per cycle while out_tready is high
// stall: when the output register holds a word and out_tready is low the
//   whole pipeline freezes and in_tready drops; nothing is lost or repeated
// reset: pipeline empties, rank = 1, dims = 0, permutation = identity
module tensor_transpose_offset #(
  parameter int MAX_RANK = 6,
  parameter int DIM_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ttoff_pkg::IDX_W-1:0]        in_tdata,   // [47:0] linear_index
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ttoff_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [47:0] out_offset
  output logic [ttoff_pkg::OUT_TUSER_W-1:0]  out_tuser,  // [0] out_of_range, [1] bad_permutation
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ttoff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttoff_pkg::CFG_W-1:0]        cfg_data
);
  import ttoff_pkg::*;

  localparam int NDIV  = MAX_RANK * NSTEP;
  localparam int CRD_W = MAX_RANK * DIM_BITS;

  logic                 en;
  logic [RANK_W-1:0]    rank_r;
  logic [DIMS_W-1:0]    dims_r;
  logic [PERM_W-1:0]    perm_r;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_RST;
      dims_r <= '0;
      perm_r <= PERM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANK: rank_r <= cfg_data[RANK_W-1:0];
        REG_DIMS: dims_r <= cfg_data[DIMS_W-1:0];
        REG_PERM: perm_r <= cfg_data[PERM_W-1:0];
        default:  ;
      endcase
    end
  end

  // decoded shape; the user keeps it stable while words are in flight, the block does not enforce it
  logic [3:0]                 rank_eff;
  logic [CRD_W+DIMS_W-1:0]    dims_wide;
  logic [MAX_RANK*AXIS_BITS+PERM_W-1:0] perm_wide;
  logic [DIM_BITS:0]          dsize [MAX_RANK];
  logic [AXIS_BITS-1:0]       pfld  [MAX_RANK];
  logic                       bad;

  assign dims_wide = {{CRD_W{1'b0}}, dims_r};
  assign perm_wide = {{(MAX_RANK*AXIS_BITS){1'b0}}, perm_r};

  always_comb begin
    if (rank_r == '0)
      rank_eff = 4'd1;
    else if ({1'b0, rank_r} > 4'(MAX_RANK))
      rank_eff = 4'(MAX_RANK);
    else
      rank_eff = {1'b0, rank_r};
    for (int i = 0; i < MAX_RANK; i++) begin
      pfld[i] = perm_wide[i*AXIS_BITS +: AXIS_BITS];
      if (4'(i) < rank_eff)
        dsize[i] = {1'b0, dims_wide[i*DIM_BITS +: DIM_BITS]} + 1'b1;
      else
        dsize[i] = (DIM_BITS+1)'(1);
    end
    bad = 1'b0;
    for (int i = 0; i < MAX_RANK; i++) begin
      if (4'(i) < rank_eff) begin
        if ({1'b0, pfld[i]} >= rank_eff) bad = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (pfld[i] == pfld[j]) bad = 1'b1;
        end
      end
    end
  end

  // divide pipeline, last axis first
  logic                 s_vld   [NDIV+1];
  logic [IDX_W-1:0]     s_work  [NDIV+1];
  logic [DIM_BITS-1:0]  s_rem   [NDIV+1];
  logic [CRD_W-1:0]     s_coord [NDIV+1];

  assign s_vld[0]   = in_tvalid & in_tready;
  assign s_work[0]  = in_tdata;
  assign s_rem[0]   = '0;
  assign s_coord[0] = '0;

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    ttoff_div_stage #(
      .DIM_BITS (DIM_BITS),
      .MAX_RANK (MAX_RANK),
      .AXIS     (MAX_RANK - 1 - s / NSTEP),
      .LAST     ((s % NSTEP) == NSTEP - 1)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_vld    (s_vld[s]),
      .in_work   (s_work[s]),
      .in_rem    (s_rem[s]),
      .in_coord  (s_coord[s]),
      .divisor   (dsize[MAX_RANK - 1 - s / NSTEP]),
      .out_vld   (s_vld[s+1]),
      .out_work  (s_work[s+1]),
      .out_rem   (s_rem[s+1]),
      .out_coord (s_coord[s+1])
    );
  end

  // recombine with output strides, one axis per stage
  logic              c_vld   [MAX_RANK+1];
  logic [IDX_W-1:0]  c_off   [MAX_RANK+1];
  logic              c_oor   [MAX_RANK+1];
  logic [CRD_W-1:0]  c_coord [MAX_RANK+1];

  assign c_vld[0]   = s_vld[NDIV];
  assign c_off[0]   = '0;
  assign c_oor[0]   = (s_work[NDIV] != '0);
  assign c_coord[0] = s_coord[NDIV];

  for (genvar c = 0; c < MAX_RANK; c++) begin : g_comb
    logic             vld_r, oor_r;
    logic [IDX_W-1:0] off_r, off_nxt;
    logic [CRD_W-1:0] coord_r;

    always_comb begin
      logic [DIM_BITS:0]   dval;
      logic [DIM_BITS-1:0] cval;
      dval = (DIM_BITS+1)'(1);
      cval = '0;
      for (int j = 0; j < MAX_RANK; j++) begin
        if (pfld[c] == AXIS_BITS'(j)) begin
          dval = dsize[j];
          cval = c_coord[c][j*DIM_BITS +: DIM_BITS];
        end
      end
      if (4'(c) < rank_eff)
        off_nxt = c_off[c] * IDX_W'(dval) + IDX_W'(cval);
      else
        off_nxt = c_off[c];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= c_vld[c];
      end
      if (en) begin
        off_r   <= off_nxt;
        oor_r   <= c_oor[c];
        coord_r <= c_coord[c];
      end
    end

    assign c_vld[c+1]   = vld_r;
    assign c_off[c+1]   = off_r;
    assign c_oor[c+1]   = oor_r;
    assign c_coord[c+1] = coord_r;
  end

  // output register
  logic                   out_tvalid_r;
  logic [IDX_W-1:0]       out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  assign en        = ~out_tvalid_r | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= c_vld[MAX_RANK];
    end
    if (en) begin
      out_tdata_r <= (c_oor[MAX_RANK] | bad) ? '0 : c_off[MAX_RANK];
      out_tuser_r <= {bad, c_oor[MAX_RANK]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[src/ttoff_div_stage.sv]
module ttoff_div_stage #(
  parameter int DIM_BITS = 8,
  parameter int MAX_RANK = 6,
  parameter int AXIS     = 0,
  parameter bit LAST     = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [ttoff_pkg::IDX_W-1:0]        in_work,
  input  logic [DIM_BITS-1:0]                in_rem,
  input  logic [MAX_RANK*DIM_BITS-1:0]       in_coord,
  input  logic [DIM_BITS:0]                  divisor,
  output logic                               out_vld,
  output logic [ttoff_pkg::IDX_W-1:0]        out_work,
  output logic [DIM_BITS-1:0]                out_rem,
  output logic [MAX_RANK*DIM_BITS-1:0]       out_coord
);
  import ttoff_pkg::*;

  logic                         vld_r;
  logic [IDX_W-1:0]             work_r, work_nxt;
  logic [DIM_BITS-1:0]          rem_r, rem_nxt;
  logic [MAX_RANK*DIM_BITS-1:0] coord_r, coord_nxt;

  // restoring division, BPS quotient bits per stage, quotient shifts into work
  always_comb begin
    logic [DIM_BITS:0]    trial;
    logic [DIM_BITS-1:0]  rem_v;
    logic [IDX_W-1:0]     work_v;
    logic                 qb;
    rem_v  = in_rem;
    work_v = in_work;
    for (int k = 0; k < BPS; k++) begin
      trial = {rem_v, work_v[IDX_W-1]};
      qb    = 1'b0;
      if (trial >= divisor) begin
        trial = trial - divisor;
        qb    = 1'b1;
      end
      rem_v  = trial[DIM_BITS-1:0];
      work_v = {work_v[IDX_W-2:0], qb};
    end
    work_nxt  = work_v;
    coord_nxt = in_coord;
    rem_nxt   = rem_v;
    if (LAST) begin
      coord_nxt[AXIS*DIM_BITS +: DIM_BITS] = rem_v;
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      work_r  <= work_nxt;
      rem_r   <= rem_nxt;
      coord_r <= coord_nxt;
    end
  end

  assign out_vld   = vld_r;
  assign out_work  = work_r;
  assign out_rem   = rem_r;
  assign out_coord = coord_r;

endmodule

[src/ttoff_checker.sv]
`include "tensor_transpose_offset_assert.svh"

module ttoff_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ttoff_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [ttoff_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);
  import ttoff_pkg::*;

  // a held result word keeps its payload
  `TTOFF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result word changed")

  // an empty output register never blocks the input
  `TTOFF_ASSERT_NOW(a_flow, !out_tvalid, in_tready, "input blocked with empty output")

  // errors force a zero offset
  `TTOFF_ASSERT_NOW(a_oor_zero, out_tvalid && out_tuser[0], out_tdata == '0, "offset not zero on out_of_range")
  `TTOFF_ASSERT_NOW(a_bad_zero, out_tvalid && out_tuser[1], out_tdata == '0, "offset not zero on bad_permutation")

  // register writes are never held off
  `TTOFF_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write held off")

endmodule

bind tensor_transpose_offset ttoff_checker u_ttoff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

[sim/tb_top.sv]
module tb_top;
  import ttoff_pkg::*;

  typedef struct packed {
    logic        is_reg;
    logic [1:0]  reg_idx;
    logic [47:0] value;
  } pending_t;

  typedef struct packed {
    logic [47:0] offset;
    logic        oor;
    logic        bad_perm;
  } offset_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IDX_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  tensor_transpose_offset DUT (.*);

  pending_t stim_q[$];
  offset_t  offset_q[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       quiet = 0;
  logic     hold_off_done = 0;
  int       hold_left = 0;

  // shadow registers
  logic [2:0]  sh_rank;
  logic [47:0] sh_dims;
  logic [17:0] sh_perm;

  function automatic longint unsigned axis_size(logic [47:0] dims, int a);
    return longint'(dims[8*a +: 8]) + 1;
  endfunction

  function automatic int eff_rank(logic [2:0] r);
    if (r == 0) return 1;
    if (r > 6) return 6;
    return int'(r);
  endfunction

  function automatic offset_t transpose_offset(logic [47:0] idx);
    offset_t res;
    longint unsigned coord[6];
    longint unsigned rest;
    longint unsigned off;
    logic [5:0] seen;
    int r;
    int a;
    r = eff_rank(sh_rank);
    rest = idx;
    off = 0;
    seen = '0;
    res = '0;
    for (int i = r - 1; i >= 0; i--) begin
      coord[i] = rest % axis_size(sh_dims, i);
      rest = rest / axis_size(sh_dims, i);
    end
    res.oor = (rest != 0);
    for (int i = 0; i < r; i++) begin
      a = int'(sh_perm[3*i +: 3]);
      if (a >= r || seen[a]) res.bad_perm = 1;
      else seen[a] = 1;
    end
    if (!res.oor && !res.bad_perm) begin
      for (int i = 0; i < r; i++) begin
        a = int'(sh_perm[3*i +: 3]);
        off = off * axis_size(sh_dims, a) + coord[a];
      end
      res.offset = off[47:0];
    end
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // idling mode: 0 receiver-heavy idle, 1 sender-heavy idle, 2 none
  function automatic int idle_mode();
    if (n_sent < 600) return 0;
    if (n_sent < 1200) return 1;
    return 2;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      cfg_valid <= 0;
      cfg_index <= '0;
      cfg_data <= '0;
      quiet <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      else if (quiet < 1000) quiet <= quiet + 1;
      if (in_tvalid && in_tready) n_sent <= n_sent + 1;
      if (cfg_valid) begin
        if (cfg_ready) cfg_valid <= 0;
      end else if (!in_tvalid || in_tready) begin
        if (stim_q.size() != 0 && !stim_q[0].is_reg) begin
          if ($urandom_range(99) >= (idle_mode() == 0 ? 34 : idle_mode() == 1 ? 46 : 0)) begin
            in_tvalid <= 1;
            in_tdata <= stim_q[0].value;
            void'(stim_q.pop_front());
          end else begin
            in_tvalid <= 0;
          end
        end else begin
          in_tvalid <= 0;
          // registers change only once the pipeline has drained
          if (stim_q.size() != 0 && !in_tvalid && offset_q.size() == 0 && quiet >= 100) begin
            cfg_valid <= 1;
            cfg_index <= stim_q[0].reg_idx;
            cfg_data <= stim_q[0].value;
            void'(stim_q.pop_front());
          end
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else if (!hold_off_done && n_sent >= 900) begin
      // long hold-off so the pipeline fills and in_tready drops
      hold_off_done <= 1;
      hold_left <= 300;
      out_tready <= 0;
    end else begin
      out_tready <= $urandom_range(99) >= (idle_mode() == 0 ? 46 : idle_mode() == 1 ? 34 : 0);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    offset_t exp_w;
    if (!rst_n) begin
      sh_rank <= RANK_RST;
      sh_dims <= '0;
      sh_perm <= PERM_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANK: sh_rank <= cfg_data[2:0];
          REG_DIMS: sh_dims <= cfg_data;
          REG_PERM: sh_perm <= cfg_data[17:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (offset_q.size() == 0) begin
          $error("result word with nothing expected: offset %0h", out_tdata);
          n_errors++;
        end else begin
          exp_w = offset_q.pop_front();
          if (out_tdata !== exp_w.offset) begin
            $error("out_offset: expected %0h, got %0h", exp_w.offset, out_tdata);
            n_errors++;
          end
          if (out_tuser[0] !== exp_w.oor) begin
            $error("out_of_range: expected %0b, got %0b", exp_w.oor, out_tuser[0]);
            n_errors++;
          end
          if (out_tuser[1] !== exp_w.bad_perm) begin
            $error("bad_permutation: expected %0b, got %0b", exp_w.bad_perm, out_tuser[1]);
            n_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) offset_q.push_back(transpose_offset(in_tdata));
    end
  end

  task automatic add_reg(logic [1:0] idx, logic [47:0] v);
    stim_q.push_back('{1'b1, idx, v});
  endtask

  task automatic add_index(logic [47:0] v);
    stim_q.push_back('{1'b0, 2'd0, v});
  endtask

  task automatic set_shape(logic [2:0] r, logic [47:0] d, logic [17:0] p);
    add_reg(REG_RANK, 48'(r));
    add_reg(REG_DIMS, d);
    add_reg(REG_PERM, 48'(p));
  endtask

  function automatic longint unsigned elem_count(logic [2:0] r, logic [47:0] d);
    longint unsigned c;
    c = 1;
    for (int i = 0; i < eff_rank(r); i++) c = c * axis_size(d, i);
    return c;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic random_phase(int n);
    logic [2:0]  r;
    logic [47:0] d;
    logic [17:0] p;
    int axes[6];
    int er;
    int j;
    int t;
    int pick;
    longint unsigned cnt;
    r = 3'($urandom_range(7));
    er = eff_rank(r);
    for (int i = 0; i < 6; i++) begin
      // mostly small axes so out-of-range and wrap cases are common
      d[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
      axes[i] = i;
    end
    for (int i = er - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = axes[i];
      axes[i] = axes[j];
      axes[j] = t;
    end
    p = 18'($urandom);
    if ($urandom_range(4) != 0)
      for (int i = 0; i < er; i++) p[3*i +: 3] = 3'(axes[i]);
    set_shape(r, d, p);
    cnt = elem_count(r, d);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      if (pick < 8) add_index(48'({$urandom, $urandom} % cnt));
      else if (pick == 8) add_index(48'(cnt - 2 + $urandom_range(3)));
      else add_index(rand48());
    end
  endtask

  initial begin
    rst_n = 0;
    // reset shape: single axis of size one
    add_index(48'd0);
    add_index(48'd1);
    add_index({48{1'b1}});
    // full 6-axis shape with every size 256, reversed axes
    set_shape(3'd6, {48{1'b1}}, {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5});
    add_index(48'd0);
    add_index({48{1'b1}});
    add_index({24{2'b10}});
    add_index({24{2'b01}});
    // rank zero acts as rank one
    set_shape(3'd0, 48'h0000_0000_0009, 18'd181896);
    add_index(48'd9);
    add_index(48'd10);
    add_index(48'd3);
    // rank above the maximum saturates, with a repeated axis
    set_shape(3'd7, 48'h0102_0304_0506, {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1});
    add_index(48'd7);
    add_index(48'd100000);
    // axis field beyond rank, also out of range together
    set_shape(3'd3, 48'h0000_0001_0203, {9'd0, 3'd4, 3'd0, 3'd1});
    add_index(48'd5);
    add_index(48'd200);
    // valid rank three transpose
    set_shape(3'd3, 48'h0000_0001_0203, {9'h1ff, 3'd0, 3'd2, 3'd1});
    add_index(48'd0);
    add_index(48'd23);
    add_index(48'd24);
    add_index(48'd13);
    for (int ph = 0; ph < 16; ph++) random_phase(108);
    repeat (7) @(posedge clk);
    rst_n <= 1;
    wait (stim_q.size() == 0 && !in_tvalid && !cfg_valid);
    wait (offset_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && offset_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ttoff_pkg.sv
src/ttoff_div_stage.sv
src/tensor_transpose_offset.sv
src/ttoff_checker.sv
sim/tb_top.sv
